// ===== hdl/rna_pkg.sv =====
// ----------------------------------------------------------------------------
// Rational number ALU package
// Shared request and result types, op codes and state encodings.
// ----------------------------------------------------------------------------
package rna_pkg;

  localparam int FieldBits = 32;

  typedef enum logic [2:0] {
    OP_MUL = 3'd0,
    OP_ADD = 3'd1,
    OP_NEG = 3'd2,
    OP_EQU = 3'd3,
    OP_RED = 3'd4
  } op_t;

  typedef struct packed {
    logic [2:0]           op;
    logic [FieldBits-1:0] a_num;
    logic [FieldBits-1:0] a_den;
    logic [FieldBits-1:0] b_num;
    logic [FieldBits-1:0] b_den;
  } req_t;

  typedef struct packed {
    logic [FieldBits-1:0] res_num;
    logic [FieldBits-1:0] res_den;
    logic                 is_equal;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_OUT
  } state_t;

endpackage

// ===== hdl/rna_front.sv =====
// ----------------------------------------------------------------------------
// Rational number ALU front end
// Accepts requests into a short queue and hands them on to the back end.
// ----------------------------------------------------------------------------
module rna_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  rna_pkg::req_t req,
  output logic          cmd_valid,
  input  logic          cmd_take,
  output rna_pkg::req_t cmd
);
  import rna_pkg::*;

  req_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  // Queue storage, written with each accepted request.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= req;
    end
  end

  assign cmd = mem[rd_ptr];

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (rst) full |=> !(count == 2'd0))
    else $error("full queue emptied without pops");
  assert property (@(posedge clk) disable iff (rst)
    (!do_push && !do_pop) |=> $stable(count))
    else $error("count moved with no request");

endmodule

// ===== hdl/rna_back.sv =====
// ----------------------------------------------------------------------------
// Rational number ALU back end
// Multiplies, adds, negates, compares, or reduces with a subtractive gcd and
// two restoring divisions; holds one result register towards the output.
// ----------------------------------------------------------------------------
module rna_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_take,
  input  rna_pkg::req_t cmd,
  output logic          empty,
  input  logic          pop,
  output rna_pkg::res_t res
);
  import rna_pkg::*;

  localparam int WORD_BITS = FieldBits;
  localparam int CntBits   = $clog2(WORD_BITS + 1);

  state_t               state, state_next;
  req_t                 cur;
  logic [WORD_BITS-1:0] an, ad, bn, bd;
  logic [WORD_BITS-1:0] x, y;
  logic [WORD_BITS-1:0] quo, rem, dvs;
  logic [CntBits-1:0]   cnt;
  logic [WORD_BITS-1:0] prod;
  logic [WORD_BITS-1:0] m_a, m_b;
  logic [WORD_BITS-1:0] acc;
  logic                 out_full;
  logic [WORD_BITS:0]   rem_sh;
  logic [WORD_BITS:0]   rem_sub;
  res_t                 res_next;

  assign an = cur.a_num[WORD_BITS-1:0];
  assign ad = cur.a_den[WORD_BITS-1:0];
  assign bn = cur.b_num[WORD_BITS-1:0];
  assign bd = cur.b_den[WORD_BITS-1:0];

  // One shared wrapping multiplier.
  always_comb begin
    m_a = ad;
    m_b = bd;
    if (state == ST_MUL1) begin
      m_a = an;
      m_b = (cur.op == OP_MUL) ? bn : bd;
    end else if (state == ST_MUL2) begin
      m_a = ad;
      m_b = bn;
    end
    prod = m_a * m_b;
  end

  // Restoring division step.
  always_comb begin
    rem_sh  = {rem, quo[WORD_BITS-1]};
    rem_sub = rem_sh - {1'b0, dvs};
  end

  assign empty    = !out_full;
  assign cmd_take = (state == ST_IDLE) && cmd_valid;

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (cmd_valid) state_next = ST_MUL1;
      ST_MUL1: begin
        if (cur.op == OP_ADD) state_next = ST_MUL2;
        else if (cur.op == OP_RED && !an[WORD_BITS-1] && an != '0
                 && !ad[WORD_BITS-1] && ad != '0) state_next = ST_GCD;
        else state_next = ST_OUT;
      end
      ST_MUL2: state_next = ST_OUT;
      ST_GCD:  if (x == y) state_next = ST_DIVN;
      ST_DIVN: if (cnt == CntBits'(WORD_BITS)) state_next = ST_DIVD;
      ST_DIVD: if (cnt == CntBits'(WORD_BITS)) state_next = ST_OUT;
      ST_OUT:  if (!out_full) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: if (cmd_valid) cur <= cmd;
      ST_MUL1: begin
        acc <= prod;
        x   <= an;
        y   <= ad;
      end
      ST_MUL2: acc <= acc + prod;
      ST_GCD: begin
        if (x > y)      x <= x - y;
        else if (y > x) y <= y - x;
        else begin
          dvs <= x;
          quo <= an;
          rem <= '0;
          cnt <= '0;
        end
      end
      ST_DIVN, ST_DIVD: begin
        if (cnt == CntBits'(WORD_BITS)) begin
          if (state == ST_DIVN) x <= quo;
          else                  y <= quo;
          quo <= ad;
          rem <= '0;
          cnt <= '0;
        end else begin
          cnt <= cnt + 1'b1;
          if (!rem_sub[WORD_BITS]) begin
            rem <= rem_sub[WORD_BITS-1:0];
            quo <= {quo[WORD_BITS-2:0], 1'b1};
          end else begin
            rem <= rem_sh[WORD_BITS-1:0];
            quo <= {quo[WORD_BITS-2:0], 1'b0};
          end
        end
      end
      default: ;
    endcase
  end

  // Result value for the current request.
  always_comb begin
    res_next = '0;
    case (cur.op)
      OP_MUL: begin
        res_next.res_num = FieldBits'(acc);
        res_next.res_den = FieldBits'(prod);
      end
      OP_ADD: begin
        res_next.res_num = FieldBits'(acc);
        res_next.res_den = FieldBits'(prod);
      end
      OP_NEG: begin
        res_next.res_num = FieldBits'(-an);
        res_next.res_den = FieldBits'(ad);
      end
      OP_EQU: res_next.is_equal = (an == bn) && (ad == bd);
      OP_RED: begin
        if (x == an && y == ad && dvs != '0 && dvs != 1) begin
          res_next.res_num = FieldBits'(an);
          res_next.res_den = FieldBits'(ad);
        end else begin
          res_next.res_num = FieldBits'(x);
          res_next.res_den = FieldBits'(y);
        end
      end
      default: ;
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else begin
      if (pop && out_full) out_full <= 1'b0;
      if (state == ST_OUT && !out_full) begin
        out_full <= 1'b1;
        res      <= res_next;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    cmd_take |=> state == ST_MUL1)
    else $error("command taken without starting");
  assert property (@(posedge clk) disable iff (rst)
    (out_full && !pop) |=> out_full)
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst)
    state == ST_GCD |-> (x != '0 && y != '0))
    else $error("gcd operand zero");

endmodule

// ===== hdl/rational_number_alu_unit.sv =====
// Multiply, negate, equal and a reduce passed through go by the MUL1 and OUT states;
// add also goes by MUL2. Reduce of two positive parts runs subtractive gcd steps
// and then two restoring divisions, of the numerator and of the denominator.
// The back end works on one request at a time and takes the next only when idle;
// a two-entry queue lets requests wait. Synchronous active-high reset empties both.
// ----------------------------------------------------------------------------
// Rational number ALU unit
// Top level: front request queue and back-end sequencer.
// ----------------------------------------------------------------------------
module rational_number_alu_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  rna_pkg::req_t in_req,
  output logic          empty,
  input  logic          pop,
  output rna_pkg::res_t out_res
);
  import rna_pkg::*;

  logic cmd_valid;
  logic cmd_take;
  req_t cmd;

  rna_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .req(in_req),
    .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
  );

  rna_back u_back (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
    .cmd(cmd), .empty(empty), .pop(pop), .res(out_res)
  );

endmodule

// ===== tb/rational_number_alu_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rational number ALU unit testbench
// Drives fraction requests through the input queue. A scoreboard predicts
// each result and checks it, in order, against the results popped from the
// block, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module rational_number_alu_unit_test;
  import rna_pkg::*;

  localparam int NumRandom = 1600;
  localparam int IdleLimit = 200000;

  // Predicts fraction results and holds those still to be popped.
  class fraction_scoreboard;
    res_t pending[$];
    int   mismatches;

    function res_t predict(req_t r);
      res_t          res;
      logic [31:0]   x;
      logic [31:0]   y;
      logic [31:0]   t;
      res = '0;
      case (r.op)
        OP_MUL: begin
          res.res_num = r.a_num * r.b_num;
          res.res_den = r.a_den * r.b_den;
        end
        OP_ADD: begin
          res.res_num = r.a_num * r.b_den + r.a_den * r.b_num;
          res.res_den = r.a_den * r.b_den;
        end
        OP_NEG: begin
          res.res_num = 32'd0 - r.a_num;
          res.res_den = r.a_den;
        end
        OP_EQU: begin
          res.is_equal = (r.a_num == r.b_num) && (r.a_den == r.b_den);
        end
        OP_RED: begin
          res.res_num = r.a_num;
          res.res_den = r.a_den;
          // Only strictly positive parts are divided by their gcd.
          if (r.a_num != 0 && !r.a_num[31] && r.a_den != 0 && !r.a_den[31]) begin
            x = r.a_num;
            y = r.a_den;
            while (y != 0) begin
              t = x % y;
              x = y;
              y = t;
            end
            res.res_num = r.a_num / x;
            res.res_den = r.a_den / x;
          end
        end
        default: res = '0;
      endcase
      return res;
    endfunction

    function void note_request(req_t r);
      pending.push_back(predict(r));
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got.res_num !== want.res_num || got.res_den !== want.res_den ||
          got.is_equal !== want.is_equal) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected num %h den %h eq %b, got num %h den %h eq %b",
                   want.res_num, want.res_den, want.is_equal,
                   got.res_num, got.res_den, got.is_equal);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic push;
  logic full;
  req_t in_req;
  logic empty;
  logic pop;
  res_t out_res;

  fraction_scoreboard board;
  bit   sending_done;
  int   popped;
  int   idle_cycles;

  rational_number_alu_unit DUT (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_req(in_req),
    .empty(empty), .pop(pop), .out_res(out_res)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Mostly short gaps, now and then a long one, often none.
  function int gap_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Offers one request and waits until the queue takes it.
  task send_request(req_t r);
    int gap;
    push   <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (full);
    board.note_request(r);
    gap = gap_length();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task send_fraction(op_t op, logic [31:0] an, logic [31:0] ad,
                     logic [31:0] bn, logic [31:0] bd);
    req_t r;
    r.op    = op;
    r.a_num = an;
    r.a_den = ad;
    r.b_num = bn;
    r.b_den = bd;
    send_request(r);
  endtask

  // Random request; reduce keeps its gcd ratio small so the subtractive loop ends soon.
  function req_t random_request();
    req_t        r;
    int          pick;
    logic [31:0] g;
    r.op    = $urandom_range(0, 99) < 94 ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
    r.a_num = $urandom();
    r.a_den = $urandom();
    r.b_num = $urandom();
    r.b_den = $urandom();
    pick = $urandom_range(0, 9);
    if (r.op == OP_EQU && pick < 5) begin
      r.b_num = r.a_num;
      r.b_den = pick < 3 ? r.a_den : r.a_den ^ (32'd1 << $urandom_range(0, 31));
    end
    if (r.op == OP_RED) begin
      if (pick < 7) begin
        g = $urandom_range(1, 1 << $urandom_range(0, 25));
        r.a_num = g * $urandom_range(1, 30);
        r.a_den = g * $urandom_range(1, 30);
      end else if (pick < 9) begin
        r.a_num = pick == 7 ? 32'd0 : r.a_num | 32'h8000_0000;
      end else begin
        r.a_den = $urandom_range(0, 1) ? 32'd0 : r.a_den | 32'h8000_0000;
      end
    end
    return r;
  endfunction

  // Sender: directed corners first, then random requests.
  initial begin
    req_t r;
    board = new();
    rst    = 1'b1;
    push   = 1'b0;
    pop    = 1'b0;
    in_req = '0;
    sending_done = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_fraction(OP_MUL, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send_fraction(OP_MUL, 32'hffff_ffff, 32'd0, 32'h8000_0000, 32'hffff_ffff);
    send_fraction(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
    send_fraction(OP_ADD, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
    send_fraction(OP_ADD, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_fraction(OP_NEG, 32'h8000_0000, 32'd5, 32'd0, 32'd0);
    send_fraction(OP_NEG, 32'd0, 32'hffff_ffff, 32'hffff_ffff, 32'd1);
    send_fraction(OP_NEG, 32'h7fff_ffff, 32'h8000_0000, 32'd3, 32'd4);
    send_fraction(OP_EQU, 32'd7, 32'd9, 32'd7, 32'd9);
    send_fraction(OP_EQU, 32'd7, 32'd9, 32'd7, 32'd8);
    send_fraction(OP_EQU, 32'd7, 32'd9, 32'd6, 32'd9);
    send_fraction(OP_EQU, 32'hffff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h8000_0000);
    send_fraction(OP_RED, 32'd12, 32'd18, 32'd0, 32'd0);
    send_fraction(OP_RED, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_fraction(OP_RED, 32'd1, 32'd1, 32'd0, 32'd0);
    send_fraction(OP_RED, 32'd7, 32'd13, 32'd0, 32'd0);
    send_fraction(OP_RED, 32'h4000_0000, 32'h6000_0000, 32'd0, 32'd0);
    send_fraction(OP_RED, 32'd0, 32'd6, 32'd0, 32'd0);
    send_fraction(OP_RED, 32'd6, 32'd0, 32'd0, 32'd0);
    send_fraction(OP_RED, 32'hffff_fffa, 32'd4, 32'd0, 32'd0);
    send_fraction(OP_RED, 32'd6, 32'h8000_0000, 32'd0, 32'd0);
    for (int code = 5; code < 8; code++) begin
      r = '1;
      r.op = 3'(code);
      send_request(r);
    end
    for (int i = 0; i < NumRandom; i++) send_request(random_request());
    push <= 1'b0;
    sending_done = 1'b1;
  end

  // Receiver: random stalls, plus one long hold-off so the queue fills up.
  initial begin
    int  stall;
    bit  held;
    held  = 1'b0;
    popped = 0;
    @(negedge rst);
    forever begin
      stall = gap_length();
      if (!held && popped == 150) begin
        held  = 1'b1;
        stall = 400;
      end
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      if (!empty) begin
        board.check_result(out_res);
        popped++;
      end
    end
  end

  // Watchdog on cycles in which no request or result moves.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // End of run: all results back, then a quiet tail for stray results.
  initial begin
    wait (sending_done);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
